### src/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int unsigned PAT_BYTES = 16;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned APB_DW    = 64;
    localparam int unsigned APB_AW    = 5;

    localparam logic [7:0]       WILDCARD_BYTE = 8'h3F;
    localparam logic [LEN_W-1:0] LEN_RESET     = 5'd1;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_START    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_region;
    } item_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_position;
    } result_t;

endpackage

### src/wbps_intf.sv
// Valid/ready channel interfaces for input and result beats.
interface wbps_item_if;
    logic              valid;
    logic              ready;
    wbps_pkg::item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wbps_result_if;
    logic              valid;
    logic              ready;
    wbps_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/wildcard_byte_pattern_scanner_core.sv
// Wildcard byte pattern scanner: window, compare pipeline, APB registers.
// Takes one byte per cycle unless the result side stalls and gives exactly one
// result beat per input beat. The input beat is captured with a snapshot of
// the byte window; the capture stage compares all pattern bytes in parallel
// against that snapshot and loads the result register when free, so a new
// byte can enter every cycle while the result side keeps up. A pattern byte
// of 0x3F matches any data byte. Matches starting before start_offset are
// suppressed; the position counter saturates at all ones. A beat with
// end_of_region set is compared normally, then clears window and position.
// Registers (64-bit APB, byte address 8*i): pattern low, pattern high,
// pattern length (0 acts as 1, capped at 16 and MAX_PATTERN), start offset.
// Write configuration only while no beat is in flight.
module wildcard_byte_pattern_scanner_core #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::APB_AW-1:0]   paddr,
    input  logic [wbps_pkg::APB_DW-1:0]   pwdata,
    output logic [wbps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    wbps_item_if.sink                     items,
    wbps_result_if.source                 results
);

    localparam int unsigned MaxLen   = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ?
                                       MAX_PATTERN : wbps_pkg::PAT_BYTES;
    localparam int unsigned WinDepth = MaxLen - 1;
    localparam int unsigned IdxW     = $clog2(MaxLen);
    localparam int unsigned LenW     = wbps_pkg::LEN_W;
    localparam int unsigned PosW     = wbps_pkg::POS_W;

    // configuration registers
    logic [63:0]     pat_low_reg;
    logic [63:0]     pat_high_reg;
    logic [LenW-1:0] pat_len_reg;
    logic [PosW-1:0] start_reg;

    // scan state
    logic [7:0]      win_reg [WinDepth];
    logic [7:0]      win_next [WinDepth];
    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;

    // capture stage
    logic            s1_valid_reg;
    logic [7:0]      s1_bytes_reg [MaxLen];
    logic [PosW-1:0] s1_pos_reg;

    // result stage
    logic            out_valid_reg;
    logic            out_found_reg;
    logic [PosW-1:0] out_pos_reg;
    logic            out_found_next;
    logic [PosW-1:0] out_pos_next;

    logic            cfg_wr;
    wbps_pkg::reg_idx_t cfg_idx;
    logic            in_acc;
    logic            s1_adv;
    logic [LenW-1:0] eff_len;
    logic [LenW-1:0] len_m1;
    logic [127:0]    pat_all;
    logic            cmp_ok;
    logic [PosW-1:0] first_pos;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = wbps_pkg::reg_idx_t'(paddr[4:3]);

    always_comb
    begin
        case (cfg_idx)
            wbps_pkg::REG_PAT_LOW:  prdata = pat_low_reg;
            wbps_pkg::REG_PAT_HIGH: prdata = pat_high_reg;
            wbps_pkg::REG_PAT_LEN:  prdata = {{(64-LenW){1'b0}}, pat_len_reg};
            wbps_pkg::REG_START:    prdata = {{(64-PosW){1'b0}}, start_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= wbps_pkg::LEN_RESET;
            start_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                wbps_pkg::REG_PAT_LOW:  pat_low_reg  <= pwdata;
                wbps_pkg::REG_PAT_HIGH: pat_high_reg <= pwdata;
                wbps_pkg::REG_PAT_LEN:  pat_len_reg  <= pwdata[LenW-1:0];
                wbps_pkg::REG_START:    start_reg    <= pwdata[PosW-1:0];
                default:                ;
            endcase
        end
    end

    // handshake: capture stage moves on when the result register is free
    assign s1_adv      = !out_valid_reg || results.ready;
    assign items.ready = !s1_valid_reg || s1_adv;
    assign in_acc      = items.valid && items.ready;

    // window shift and saturating position
    always_comb
    begin
        if (items.payload.end_of_region)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                win_next[i] = '0;
            end
            pos_next = '0;
        end
        else
        begin
            win_next[0] = items.payload.data_byte;
            for (int i = 1; i < WinDepth; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
            pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WinDepth; i++)
            begin
                win_reg[i] <= '0;
            end
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                win_reg <= win_next;
                pos_reg <= pos_next;
            end
            if (items.ready)
            begin
                s1_valid_reg <= items.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_bytes_reg[0] <= items.payload.data_byte;
            for (int i = 1; i < MaxLen; i++)
            begin
                s1_bytes_reg[i] <= win_reg[i-1];
            end
            s1_pos_reg <= pos_reg;
        end
    end

    // parallel compare against the captured window
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            eff_len = LenW'(1);
        end
        else if (pat_len_reg > LenW'(MaxLen))
        begin
            eff_len = LenW'(MaxLen);
        end
        else
        begin
            eff_len = pat_len_reg;
        end
    end

    assign len_m1    = eff_len - 1'b1;
    assign pat_all   = {pat_high_reg, pat_low_reg};
    assign first_pos = s1_pos_reg - {{(PosW-LenW){1'b0}}, len_m1};

    always_comb
    begin
        logic [LenW-1:0] j;
        logic [7:0]      pb;
        cmp_ok = 1'b1;
        for (int k = 0; k < MaxLen; k++)
        begin
            j  = len_m1 - LenW'(k);
            pb = pat_all[8*k +: 8];
            if ((LenW'(k) < eff_len) && (pb != wbps_pkg::WILDCARD_BYTE) &&
                (pb != s1_bytes_reg[j[IdxW-1:0]]))
            begin
                cmp_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_found_next = (s1_pos_reg >= {{(PosW-LenW){1'b0}}, len_m1}) &&
                         (first_pos >= start_reg) && cmp_ok;
        out_pos_next   = out_found_next ? first_pos : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_found_reg <= out_found_next;
            out_pos_reg   <= out_pos_next;
        end
    end

    assign results.valid                  = out_valid_reg;
    assign results.payload.match_found    = out_found_reg;
    assign results.payload.match_position = out_pos_reg;

    // checks
    a_pos_zero_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.payload.match_found) |->
        (results.payload.match_position == '0))
        else $error("match_position not zero without a match");

    a_match_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.payload.match_found) |->
        (results.payload.match_position >= start_reg))
        else $error("match reported before start offset");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !results.ready) |-> !items.ready)
        else $error("input taken while pipeline is blocked");

    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && items.payload.end_of_region) |=> (pos_reg == '0))
        else $error("position not cleared after region end");

    a_pos_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !items.payload.end_of_region && (pos_reg == '1)) |=>
        (pos_reg == '1))
        else $error("position wrapped");

endmodule

### test/wbps_scan_checker.sv
// Watches the scanner's channels and APB writes, predicts each match beat and compares.
module wbps_scan_checker #(
    parameter int unsigned MAX_PATTERN = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wbps_pkg::APB_AW-1:0] paddr,
    input  logic [wbps_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    wbps_item_if                        items,
    wbps_result_if                      results,
    output int                          errors,
    output int                          hit_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HIST_DEPTH = MAX_PATTERN - 1;

    logic [63:0]                sig_low;
    logic [63:0]                sig_high;
    logic [wbps_pkg::LEN_W-1:0] sig_len;
    logic [wbps_pkg::POS_W-1:0] min_start;

    logic [7:0]                 history [HIST_DEPTH];
    logic [wbps_pkg::POS_W-1:0] region_pos;

    wbps_pkg::result_t match_queue [$];

    function automatic wbps_pkg::result_t scan_byte(input wbps_pkg::item_t it);
        wbps_pkg::result_t          r;
        int unsigned                len;
        int unsigned                k;
        logic [127:0]               sig_all;
        logic [7:0]                 sig;
        logic [7:0]                 seen;
        logic [wbps_pkg::POS_W-1:0] first;
        logic                       hit;
        r = '0;
        sig_all = {sig_high, sig_low};
        len = (sig_len == 0) ? 1 : sig_len;
        if (len > wbps_pkg::PAT_BYTES)
            len = wbps_pkg::PAT_BYTES;
        if (len > MAX_PATTERN)
            len = MAX_PATTERN;
        if (region_pos >= len - 1)
        begin
            first = region_pos - (len - 1);
            hit = (first >= min_start);
            for (k = 0; k < len; k++)
            begin
                sig = sig_all[8*k +: 8];
                seen = (k == len - 1) ? it.data_byte : history[len - 2 - k];
                if (sig != wbps_pkg::WILDCARD_BYTE && sig != seen)
                    hit = 1'b0;
            end
            if (hit)
            begin
                r.match_found = 1'b1;
                r.match_position = first;
            end
        end
        if (it.end_of_region)
        begin
            for (k = 0; k < HIST_DEPTH; k++)
                history[k] = '0;
            region_pos = '0;
        end
        else
        begin
            for (k = HIST_DEPTH - 1; k > 0; k--)
                history[k] = history[k - 1];
            history[0] = it.data_byte;
            if (region_pos != '1)
                region_pos = region_pos + 1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        wbps_pkg::result_t want;
        wbps_pkg::result_t got;
        int                i;
        if (!rst_n)
        begin
            sig_low    = '0;
            sig_high   = '0;
            sig_len    = wbps_pkg::LEN_RESET;
            min_start  = '0;
            region_pos = '0;
            for (i = 0; i < HIST_DEPTH; i++)
                history[i] = '0;
            match_queue.delete();
            errors    = 0;
            hit_count = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (wbps_pkg::reg_idx_t'(paddr[4:3]))
                    wbps_pkg::REG_PAT_LOW:  sig_low   = pwdata;
                    wbps_pkg::REG_PAT_HIGH: sig_high  = pwdata;
                    wbps_pkg::REG_PAT_LEN:  sig_len   = pwdata[wbps_pkg::LEN_W-1:0];
                    wbps_pkg::REG_START:    min_start = pwdata[wbps_pkg::POS_W-1:0];
                    default: ;
                endcase
            end
            if (items.valid && items.ready)
                match_queue.insert(match_queue.size(), scan_byte(items.payload));
            if (results.valid && results.ready)
            begin
                got = results.payload;
                if (match_queue.size() == 0)
                begin
                    $error("match beat with no prediction: found %0d position %0h",
                           got.match_found, got.match_position);
                    errors++;
                end
                else
                begin
                    want = match_queue.pop_front();
                    if (want.match_found)
                        hit_count++;
                    if (got.match_found !== want.match_found)
                    begin
                        $error("match_found: expected %0d, got %0d",
                               want.match_found, got.match_found);
                        errors++;
                    end
                    if (got.match_position !== want.match_position)
                    begin
                        $error("match_position: expected %0h, got %0h",
                               want.match_position, got.match_position);
                        errors++;
                    end
                end
            end
            pending <= match_queue.size();
        end
    end

endmodule

### test/wildcard_byte_pattern_scanner_core_tb.sv
// Testbench top: clock, reset, byte and APB stimulus, match sink and verdict.
module wildcard_byte_pattern_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAXP = 16;
    localparam int unsigned TOTAL_BYTES = 1550;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [wbps_pkg::APB_AW-1:0] paddr;
    logic [wbps_pkg::APB_DW-1:0] pwdata;
    logic [wbps_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int errors;
    int hit_count;
    int pending;
    int sent;
    int settings;
    int beats_back;
    logic byte_burst;

    wbps_item_if   byte_ch ();
    wbps_result_if match_ch ();

    wildcard_byte_pattern_scanner_core #(.MAX_PATTERN(MAXP)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .items   (byte_ch),
        .results (match_ch)
    );

    wbps_scan_checker #(.MAX_PATTERN(MAXP)) scan_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .items     (byte_ch),
        .results   (match_ch),
        .errors    (errors),
        .hit_count (hit_count),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 3))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h41;
                default: b = wbps_pkg::WILDCARD_BYTE;
            endcase
        end
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eor);
        wbps_pkg::item_t it;
        int              gap;
        if (sent % 64 == 0)
            byte_burst = ($urandom_range(0, 3) == 0);
        gap = byte_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.data_byte = b;
        it.end_of_region = eor;
        byte_ch.valid <= 1'b1;
        byte_ch.payload <= it;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves psel high so back-to-back writes never drop and raise it in one step
    task automatic apb_write(input wbps_pkg::reg_idx_t idx,
                             input logic [wbps_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [wbps_pkg::LEN_W-1:0] len,
                             input logic [wbps_pkg::POS_W-1:0] off);
        logic [wbps_pkg::APB_DW-1:0] junk;
        byte_ch.valid <= 1'b0;
        wait_idle();
        apb_write(wbps_pkg::REG_PAT_LOW, lo);
        apb_write(wbps_pkg::REG_PAT_HIGH, hi);
        junk = {$urandom, $urandom};
        junk[wbps_pkg::LEN_W-1:0] = len;
        apb_write(wbps_pkg::REG_PAT_LEN, junk);
        junk = {$urandom, $urandom};
        junk[wbps_pkg::POS_W-1:0] = off;
        apb_write(wbps_pkg::REG_START, junk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic random_phase();
        logic [7:0]                 sig [wbps_pkg::PAT_BYTES];
        logic [63:0]                lo;
        logic [63:0]                hi;
        logic [wbps_pkg::LEN_W-1:0] len;
        logic [wbps_pkg::POS_W-1:0] off;
        logic [7:0]                 b;
        int unsigned                eff;
        int unsigned                k;
        int                         stop;
        int                         bad;
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
        endcase
        eff = (len == 0) ? 1 : (len > 16) ? 16 : len;
        for (k = 0; k < wbps_pkg::PAT_BYTES; k++)
        begin
            if (k < eff && $urandom_range(0, 9) < 2)
                sig[k] = wbps_pkg::WILDCARD_BYTE;
            else if (k < eff && $urandom_range(0, 3) != 0)
                sig[k] = noise_byte();
            else
                sig[k] = 8'($urandom_range(0, 255));
        end
        for (k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = sig[k];
            hi[8*k +: 8] = sig[k + 8];
        end
        case ($urandom_range(0, 9))
            4, 5, 6: off = $urandom_range(1, 40);
            7:       off = '1;
            8:       off = $urandom;
            9:       off = $urandom_range(0, 8);
            default: off = '0;
        endcase
        configure(lo, hi, len, off);
        stop = sent + $urandom_range(150, 230);
        if (stop > TOTAL_BYTES)
            stop = TOTAL_BYTES;
        while (sent < stop)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // planted signature, occasionally with one bit spoilt
                bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, eff - 1) : eff;
                for (k = 0; k < eff; k++)
                begin
                    b = (sig[k] == wbps_pkg::WILDCARD_BYTE) ? noise_byte() : sig[k];
                    if (k == bad)
                        b = b ^ (8'h01 << $urandom_range(0, 7));
                    send_byte(b, $urandom_range(0, 39) == 0);
                end
            end
            else
                send_byte(noise_byte(), $urandom_range(0, 39) == 0);
        end
    endtask

    // result side: random gaps, bursts, and a long hold-off now and then
    initial
    begin : match_sink
        int   gap;
        logic burst;
        match_ch.ready <= 1'b0;
        beats_back = 0;
        burst = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (beats_back % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                match_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            match_ch.ready <= 1'b1;
            @(posedge clk);
            while (!match_ch.valid)
                @(posedge clk);
            beats_back++;
            if (beats_back % 400 == 150)
            begin
                match_ch.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int k;
        rst_n = 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        sent = 0;
        settings = 0;
        byte_burst = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset pattern: single zero byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);

        // zero length behaves as one, wildcard hits anything
        configure(64'h3F3F_3F3F_3F3F_3F3F, 64'h0, 5'd0, 32'd0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);

        // oversize length clamps to sixteen; wildcard inside a full-width signature
        configure(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_3F08, 5'd31, 32'd0);
        for (k = 0; k < 16; k++)
            send_byte((k == 9) ? 8'hEE : 8'(k), k == 15);

        // matches before the start offset are suppressed
        configure(64'h3F, 64'h0, 5'd1, 32'd2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);

        while (sent < TOTAL_BYTES)
            random_phase();

        byte_ch.valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);

        $display("Scanned %0d bytes under %0d register settings; %0d matches reported.",
                 sent, settings, hit_count);
        $display("Match beats returned: %0d, mismatches: %0d.", beats_back, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/wbps_pkg.sv
src/wbps_intf.sv
src/wildcard_byte_pattern_scanner_core.sv
test/wbps_scan_checker.sv
test/wildcard_byte_pattern_scanner_core_tb.sv
